// File: rtl/core/rstt_pkg.sv
// Package for the request slot table: payload structs, command and result codes,
// and the sequencer state type. It depends on nothing else.
`timescale 1ns / 1ps
package rstt_pkg;

	typedef logic [2:0] cmd_t;
	typedef logic [2:0] kind_t;

	localparam cmd_t CMD_ALLOC = 3'd0;
	localparam cmd_t CMD_ARM   = 3'd1;
	localparam cmd_t CMD_POST  = 3'd2;
	localparam cmd_t CMD_FREE  = 3'd3;
	localparam cmd_t CMD_SCAN  = 3'd4;
	localparam cmd_t CMD_RESET = 3'd5;

	localparam kind_t KIND_ALLOCATED = 3'd0;
	localparam kind_t KIND_ARMED     = 3'd1;
	localparam kind_t KIND_COMPLETED = 3'd2;
	localparam kind_t KIND_FREED     = 3'd3;
	localparam kind_t KIND_TIMED_OUT = 3'd4;
	localparam kind_t KIND_CONN_RST  = 3'd5;
	localparam kind_t KIND_NO_SPACE  = 3'd6;
	localparam kind_t KIND_STALE     = 3'd7;

	localparam logic [7:0] TIMEOUT_LIMIT = 8'd180;
	localparam logic [5:0] MAX_OUT_M1    = 6'd31;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] now;
		logic [4:0]  slot;
		logic [31:0] tag;
		logic [7:0]  timeout_secs;
		logic [15:0] conn_id;
		logic [15:0] node_id;
		logic        match_conn;
		logic        match_node;
		logic [15:0] retval_in;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  slot_out;
		logic [31:0] tag_out;
		logic [15:0] code_out;
		logic        last;
	} rsp_t;

	// Classified command as it waits in the queue.
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] now;
		logic [4:0]  slot;
		logic        slot_ok;
		logic [31:0] tag;
		logic [7:0]  tmo;
		logic [15:0] conn;
		logic [15:0] node;
		logic        mc;
		logic        mn;
		logic [15:0] code;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_RD,
		ST_EX,
		ST_FIN
	} st_t;

endpackage

// File: rtl/core/rstt_front.sv
// Front end of the request slot table: takes commands, classifies them and
// holds them in a two-entry queue. Depends on rstt_pkg.
`timescale 1ns / 1ps
module rstt_front import rstt_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  req_t  item,
	output logic  q_valid,
	input  logic  q_pop,
	output item_t q_item
);

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      cls;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = ent_q[rd_ptr_q];

	always_comb begin
		cls.cmd     = item.cmd;
		cls.now     = item.now;
		cls.slot    = item.slot;
		cls.slot_ok = (int'(item.slot) < SLOTS);
		cls.tag     = item.tag;
		cls.tmo     = (item.timeout_secs > TIMEOUT_LIMIT) ? TIMEOUT_LIMIT : item.timeout_secs;
		cls.conn    = item.conn_id;
		cls.node    = item.node_id;
		cls.mc      = item.match_conn;
		cls.mn      = item.match_node;
		cls.code    = item.retval_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// File: rtl/core/rstt_back.sv
// Back end of the request slot table: the slot state, its memories and the
// sequencer that walks slots one per cycle, with an extra execute state for each armed slot. Depends on rstt_pkg.
`timescale 1ns / 1ps
module rstt_back import rstt_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] scan_interval,
	input  logic       q_valid,
	output logic       q_pop,
	input  item_t      q_item,
	output logic       result_valid,
	output rsp_t       result
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	st_t state_q, state_d;

	logic [SLOTS-1:0] in_use_q, armed_q, prev_vld_q;
	logic [IW-1:0]    cursor_q, idx_q, cnt_q;
	logic [31:0]      seq_q, lst_q;
	logic [5:0]       n_q;
	logic             pend_vld_q, res_vld_q;
	rsp_t             pend_q, res_q;
	item_t            it_q;

	// Slot memories, read at the walk index every cycle.
	logic [31:0] cur_m  [SLOTS];
	logic [31:0] prev_m [SLOTS];
	logic [31:0] dl_m   [SLOTS];
	logic [15:0] conn_m [SLOTS];
	logic [15:0] node_m [SLOTS];
	logic [31:0] rd_cur_q, rd_prev_q, rd_dl_q;
	logic [15:0] rd_conn_q, rd_node_q;

	logic        walk, cand, live, hit, last_idx;
	logic [31:0] cur_tag_v, prev_v, s1, alloc_tag, dl_v;
	logic        emit_en, wr_cur, wr_arm, rel;
	rsp_t        emit_r;
	logic        out_en;
	rsp_t        out_r;
	logic        scan_due, scan_back;

	assign walk      = (it_q.cmd == CMD_SCAN) || (it_q.cmd == CMD_RESET);
	assign last_idx  = (idx_q == LAST_IDX);
	assign cand      = in_use_q[idx_q] && armed_q[idx_q];
	assign cur_tag_v = in_use_q[idx_q] ? rd_cur_q : 32'd0;
	assign prev_v    = prev_vld_q[idx_q] ? rd_prev_q : 32'd0;
	assign s1        = seq_q + 32'd1;
	assign alloc_tag = (s1 == prev_v) ? (s1 + 32'd1) : s1;
	assign dl_v      = it_q.now + {24'd0, it_q.tmo};
	assign live      = it_q.slot_ok && in_use_q[idx_q] && (rd_cur_q == it_q.tag);
	assign hit       = (it_q.cmd == CMD_SCAN) ? (it_q.now > rd_dl_q)
	                 : ((it_q.mc && (rd_conn_q == it_q.conn)) ||
	                    (it_q.mn && (rd_node_q == it_q.node)));
	assign scan_back = (q_item.now < lst_q);
	assign scan_due  = ((q_item.now - lst_q) > {24'd0, scan_interval});
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_item.cmd)
						CMD_ALLOC: state_d = ST_SRCH;
						CMD_ARM, CMD_POST, CMD_FREE, CMD_RESET: state_d = ST_RD;
						CMD_SCAN: state_d = (!scan_back && scan_due) ? ST_RD : ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SRCH: begin
				if (!in_use_q[idx_q]) begin
					state_d = ST_RD;
				end else if (cnt_q == LAST_IDX) begin
					state_d = ST_FIN;
				end
			end
			ST_RD: begin
				if (walk && !cand) begin
					state_d = last_idx ? ST_FIN : ST_RD;
				end else begin
					state_d = ST_EX;
				end
			end
			ST_EX: begin
				if (!walk || last_idx || (hit && n_q == MAX_OUT_M1)) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Results and slot updates.
	always_comb begin
		emit_en = 1'b0;
		emit_r  = '0;
		wr_cur  = 1'b0;
		wr_arm  = 1'b0;
		rel     = 1'b0;
		case (state_q)
			ST_SRCH: begin
				if (in_use_q[idx_q] && cnt_q == LAST_IDX) begin
					emit_en     = 1'b1;
					emit_r.kind = KIND_NO_SPACE;
				end
			end
			ST_EX: begin
				emit_r.slot_out = 5'(idx_q);
				emit_r.tag_out  = cur_tag_v;
				case (it_q.cmd)
					CMD_ALLOC: begin
						emit_en        = 1'b1;
						wr_cur         = 1'b1;
						emit_r.kind    = KIND_ALLOCATED;
						emit_r.tag_out = alloc_tag;
					end
					CMD_ARM, CMD_POST, CMD_FREE: begin
						emit_en = 1'b1;
						if (!live) begin
							emit_r.kind     = KIND_STALE;
							emit_r.slot_out = it_q.slot;
							emit_r.tag_out  = it_q.slot_ok ? cur_tag_v : 32'd0;
						end else if (it_q.cmd == CMD_ARM) begin
							emit_r.kind = KIND_ARMED;
							wr_arm      = 1'b1;
						end else if (it_q.cmd == CMD_POST) begin
							emit_r.kind     = KIND_COMPLETED;
							emit_r.code_out = it_q.code;
							rel             = 1'b1;
						end else begin
							emit_r.kind = KIND_FREED;
							rel         = 1'b1;
						end
					end
					CMD_SCAN, CMD_RESET: begin
						if (hit) begin
							emit_en     = 1'b1;
							rel         = 1'b1;
							emit_r.kind = (it_q.cmd == CMD_SCAN) ? KIND_TIMED_OUT : KIND_CONN_RST;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		// A result is held back until the next one or the finish state, so the final one can carry last.
		out_en      = pend_vld_q && (emit_en || state_q == ST_FIN);
		out_r       = pend_q;
		out_r.last  = (state_q == ST_FIN);
	end

	always_ff @(posedge clk) begin
		if (wr_cur) begin
			cur_m[idx_q] <= alloc_tag;
		end
		if (rel) begin
			prev_m[idx_q] <= cur_tag_v;
		end
		if (wr_arm) begin
			dl_m[idx_q]   <= dl_v;
			conn_m[idx_q] <= it_q.conn;
			node_m[idx_q] <= it_q.node;
		end
		rd_cur_q  <= cur_m[idx_q];
		rd_prev_q <= prev_m[idx_q];
		rd_dl_q   <= dl_m[idx_q];
		rd_conn_q <= conn_m[idx_q];
		rd_node_q <= node_m[idx_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_q <= q_item;
		end
		if (emit_en) begin
			pend_q <= emit_r;
		end
		res_q <= out_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_use_q   <= '0;
			armed_q    <= '0;
			prev_vld_q <= '0;
			cursor_q   <= '0;
			idx_q      <= '0;
			cnt_q      <= '0;
			seq_q      <= 32'd0;
			lst_q      <= 32'd0;
			n_q        <= 6'd0;
			pend_vld_q <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_vld_q <= out_en;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cnt_q <= '0;
						n_q   <= 6'd0;
						case (q_item.cmd)
							CMD_ALLOC: idx_q <= cursor_q;
							CMD_ARM, CMD_POST, CMD_FREE:
								idx_q <= q_item.slot_ok ? IW'(q_item.slot) : '0;
							CMD_SCAN: begin
								idx_q <= '0;
								if (scan_back || scan_due) begin
									lst_q <= q_item.now;
								end
							end
							default: idx_q <= '0;
						endcase
					end
				end
				ST_SRCH: begin
					if (in_use_q[idx_q]) begin
						idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RD: begin
					if (walk && !cand && !last_idx) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EX: begin
					if (walk && !last_idx) begin
						idx_q <= idx_q + 1'b1;
					end
					if (wr_cur) begin
						in_use_q[idx_q] <= 1'b1;
						seq_q           <= alloc_tag;
						cursor_q        <= last_idx ? '0 : idx_q + 1'b1;
					end
					if (wr_arm) begin
						armed_q[idx_q] <= (dl_v != 32'd0);
					end
					if (rel) begin
						in_use_q[idx_q]   <= 1'b0;
						armed_q[idx_q]    <= 1'b0;
						prev_vld_q[idx_q] <= 1'b1;
						n_q               <= n_q + 6'd1;
					end
				end
				default: ;
			endcase
			if (emit_en) begin
				pend_vld_q <= 1'b1;
			end else if (state_q == ST_FIN) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

// File: rtl/core/request_slot_table_with_timeouts.sv
// Top level of the request slot table with timeouts: front queue, back
// sequencer and the scan interval register. Depends on rstt_pkg, rstt_front, rstt_back.
//
// Channel   Direction  Signals                          Transfer when
// command   in         start, busy, item (req_t)        start && !busy
// config    in         cfg_valid, cfg_ready, cfg_data   cfg_valid && cfg_ready
// result    out        result_valid, result (rsp_t)     result_valid (one cycle)
//
// Allocate searches for a free slot from the cursor, arm, post and free act on the named
// slot, and scan (when due) and reset walk the slots: the sequencer visits one slot per cycle and
// takes an extra execute state after the registered memory read of each armed slot.
// A two-entry queue takes commands while the sequencer works; busy rises when it is full.
// Reset empties the table, the queue and the sequencer; scan_interval resets to 1.
// Results cannot be held off by the receiver.
`timescale 1ns / 1ps
module request_slot_table_with_timeouts import rstt_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output logic       result_valid,
	output rsp_t       result
);

	logic       q_valid;
	logic       q_pop;
	item_t      q_item;
	logic [7:0] scan_interval_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_interval_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			scan_interval_q <= cfg_data;
		end
	end

	rstt_front #(.SLOTS(SLOTS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	rstt_back #(.SLOTS(SLOTS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.scan_interval (scan_interval_q),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_item        (q_item),
		.result_valid  (result_valid),
		.result        (result)
	);

endmodule

// File: rtl/core/rstt_checker.sv
// Port-level checks for the request slot table, bound to the top level.
// Depends on rstt_pkg and request_slot_table_with_timeouts.
`timescale 1ns / 1ps
module rstt_checker import rstt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic result_valid,
	input rsp_t result
);

	// Only a completion carries a code.
	a_code_only_on_post: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_COMPLETED |-> result.code_out == 16'd0)
		else $error("completion code on a result that is not a completion");

	// A full table answers with a single empty result.
	a_no_space_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_NO_SPACE |->
		result.slot_out == 5'd0 && result.tag_out == 32'd0 && result.last)
		else $error("malformed no-space result");

	// Allocation, arm and free, and any stale result, give exactly one result.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_ALLOCATED || result.kind == KIND_ARMED ||
		result.kind == KIND_FREED || result.kind == KIND_STALE) |-> result.last)
		else $error("single-result command without last");

	// A walk result that is not last is followed by another result of the same walk.
	a_walk_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> !result_valid ||
		result.kind == $past(result.kind))
		else $error("walk results mixed with another command");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind request_slot_table_with_timeouts rstt_checker u_rstt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.result_valid (result_valid),
	.result       (result)
);
